/* src/utf8_to_utf16_stream_transcoder_macros.svh */
// assertion macros used by the transcoder datapath
`ifndef UTF8_TO_UTF16_STREAM_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16_STREAM_TRANSCODER_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define U2U_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define U2U_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/u2u_pkg.sv */
// shared types, constants and helpers of the utf-8 to utf-16 transcoder
package u2u_pkg;

	localparam logic [15:0] REPL_UNIT = 16'hFFFD;
	localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
	localparam logic [5:0]  LO_SURR_TAG = 6'b110111;
	localparam logic [20:0] SUPP_BASE = 21'h010000;
	localparam logic [20:0] MAX_CP = 21'h10FFFF;
	localparam logic [15:0] SURR_FIRST = 16'hD800;
	localparam logic [15:0] SURR_LAST = 16'hDFFF;
	localparam logic [15:0] MIN_CP3 = 16'h0800;
	localparam logic [10:0] MIN_CP2 = 11'h080;

	localparam logic [0:0] OP_DATA = 1'b0;
	localparam logic [0:0] OP_EOS = 1'b1;

	localparam logic [2:0] LEN_1 = 3'd1;
	localparam logic [2:0] LEN_2 = 3'd2;
	localparam logic [2:0] LEN_3 = 3'd3;
	localparam logic [2:0] LEN_4 = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} u2u_state_t;

	typedef struct packed {
		logic load;
		logic emit;
		logic flush;
	} u2u_cmd_t;

	typedef struct packed {
		logic done;
		logic held_nz;
		logic out_free;
	} u2u_status_t;

	// sequence length announced by a lead byte; a stray or invalid lead counts as one
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] n;
		n = LEN_1;
		if (b[7:5] == 3'b110)
			n = LEN_2;
		else if (b[7:4] == 4'b1110)
			n = LEN_3;
		else if (b[7:3] == 5'b11110)
			n = LEN_4;
		return n;
	endfunction

endpackage

/* src/u2u_ctrl.sv */
// controller state machine of the transcoder
module u2u_ctrl import u2u_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [0:0]  opcode,
	output logic        in_ready,
	input  u2u_status_t st,
	output u2u_cmd_t    cmd
);

	u2u_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (opcode == OP_DATA)
						state_nx = ST_RUN;
					else if (st.held_nz)
						state_nx = ST_FLUSH;
				end
			end
			ST_RUN: begin
				if (st.done)
					state_nx = ST_IDLE;
			end
			ST_FLUSH: begin
				if (st.out_free)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid && (opcode == OP_DATA);
			end
			ST_RUN: begin
				cmd.emit = !st.done && st.out_free;
			end
			ST_FLUSH: begin
				cmd.flush = st.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

/* src/u2u_dpath.sv */
// byte window, decoder and output register of the transcoder
`include "utf8_to_utf16_stream_transcoder_macros.svh"
module u2u_dpath import u2u_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        out_ready,
	input  u2u_cmd_t    cmd,
	output u2u_status_t st,
	output logic        out_valid,
	output logic [15:0] code_unit,
	output logic        last_unit
);

	// window, oldest byte in w0; held bytes stay here between beats
	logic [7:0]  w0_q, w1_q, w2_q, w3_q;
	logic [2:0]  cnt_q;
	logic        phase_q;
	logic        out_valid_q;
	logic [15:0] unit_q;
	logic        last_q;

	logic [2:0]  len_raw, eff_len, rem_after, nxt_len;
	logic        incomplete, bad_lead, seq_ok, pair, last_calc, out_free;
	logic        c1, c2, c3;
	logic [10:0] cp2;
	logic [15:0] cp3;
	logic [20:0] cp4;
	logic [19:0] v;
	logic [15:0] single_unit, hi_unit, lo_unit;
	logic [7:0]  nxt_byte;

	assign len_raw = lead_len(w0_q);
	assign bad_lead = (w0_q[7:6] == 2'b10) || (w0_q[7:3] == 5'b11111);
	assign incomplete = len_raw > cnt_q;

	assign c1 = w1_q[7:6] == 2'b10;
	assign c2 = w2_q[7:6] == 2'b10;
	assign c3 = w3_q[7:6] == 2'b10;
	assign cp2 = {w0_q[4:0], w1_q[5:0]};
	assign cp3 = {w0_q[3:0], w1_q[5:0], w2_q[5:0]};
	assign cp4 = {w0_q[2:0], w1_q[5:0], w2_q[5:0], w3_q[5:0]};
	assign v = 20'(cp4 - SUPP_BASE);
	assign hi_unit = {HI_SURR_TAG, v[19:10]};
	assign lo_unit = {LO_SURR_TAG, v[9:0]};

	always_comb begin
		seq_ok = 1'b1;
		unique case (len_raw)
			LEN_2: seq_ok = c1 && (cp2 >= MIN_CP2);
			LEN_3: seq_ok = c1 && c2 && (cp3 >= MIN_CP3)
				&& !((cp3 >= SURR_FIRST) && (cp3 <= SURR_LAST));
			LEN_4: seq_ok = c1 && c2 && c3 && (cp4 >= SUPP_BASE) && (cp4 <= MAX_CP);
			default: seq_ok = 1'b1;
		endcase
	end

	always_comb begin
		eff_len = LEN_1;
		pair = 1'b0;
		single_unit = REPL_UNIT;
		if (len_raw == LEN_1) begin
			single_unit = bad_lead ? REPL_UNIT : {8'h00, w0_q};
		end else if (seq_ok) begin
			eff_len = len_raw;
			unique case (len_raw)
				LEN_2: single_unit = {5'b0, cp2};
				LEN_3: single_unit = cp3;
				default: pair = 1'b1;
			endcase
		end
	end

	// look one sequence ahead to mark the last unit of this beat
	assign rem_after = cnt_q - eff_len;
	always_comb begin
		case (eff_len)
			LEN_1: nxt_byte = w1_q;
			LEN_2: nxt_byte = w2_q;
			default: nxt_byte = w3_q;
		endcase
	end
	assign nxt_len = lead_len(nxt_byte);
	assign last_calc = (rem_after == 3'd0) || (nxt_len > rem_after);

	assign out_free = !out_valid_q || out_ready;
	assign st.done = (cnt_q == 3'd0) || incomplete;
	assign st.held_nz = cnt_q != 3'd0;
	assign st.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			phase_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q <= cnt_q + 3'd1;
		end else if (cmd.flush) begin
			cnt_q <= 3'd0;
		end else if (cmd.emit) begin
			if (pair && !phase_q) begin
				phase_q <= 1'b1;
			end else begin
				phase_q <= 1'b0;
				cnt_q <= rem_after;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			case (cnt_q[1:0])
				2'd0: w0_q <= data_byte;
				2'd1: w1_q <= data_byte;
				2'd2: w2_q <= data_byte;
				default: w3_q <= data_byte;
			endcase
		end else if (cmd.emit && !(pair && !phase_q)) begin
			case (eff_len)
				LEN_1: begin
					w0_q <= w1_q;
					w1_q <= w2_q;
					w2_q <= w3_q;
				end
				LEN_2: begin
					w0_q <= w2_q;
					w1_q <= w3_q;
				end
				LEN_3: w0_q <= w3_q;
				default: w0_q <= w0_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit || cmd.flush)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.flush) begin
			unit_q <= REPL_UNIT;
			last_q <= 1'b1;
		end else if (cmd.emit) begin
			if (pair && !phase_q) begin
				unit_q <= hi_unit;
				last_q <= 1'b0;
			end else begin
				unit_q <= pair ? lo_unit : single_unit;
				last_q <= last_calc;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign code_unit = unit_q;
	assign last_unit = last_q;

	`U2U_ASSERT_NOW(a_load_room, cmd.load, cnt_q <= 3'd3, "byte loaded into a full window")
	`U2U_ASSERT_NOW(a_emit_slot, cmd.emit || cmd.flush, out_free, "unit written over a waiting unit")
	`U2U_ASSERT_NOW(a_phase_pair, phase_q, pair && !st.done, "low surrogate pending without a pair")
	`U2U_ASSERT_NEXT(a_flush_unit, cmd.flush, out_valid_q && last_q && (unit_q == REPL_UNIT) && (cnt_q == 3'd0), "flush did not give a lone replacement")

endmodule

/* src/utf8_to_utf16_stream_transcoder.sv */
// top level of the utf-8 to utf-16 stream transcoder
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------
//  in      | sink      | in_valid / in_ready | opcode, data_byte
//  out     | source    | out_valid/out_ready | code_unit, last_unit
//
// a data beat is taken in idle, then the run state releases the code units
// that it yields (zero to four) and closes with a step back to idle
// an end-of-stream beat with bytes held goes through flush, giving a replacement
// the single output register sets the pace: one unit a cycle while out_ready is high
// reset clears the held count, the surrogate phase, the state and the output valid
// a stalled output holds the decoder on its current unit; input stays blocked till idle
module utf8_to_utf16_stream_transcoder import u2u_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [0:0]  opcode,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_unit,
	output logic        last_unit
);

	// commands from the controller, status back from the datapath
	u2u_cmd_t    cmd;
	u2u_status_t st;

	// sequencer: idle / decode run / end-of-stream replacement
	u2u_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// byte window with the held bytes, sequence decoder, surrogate split, output register
	u2u_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.out_ready (out_ready),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.code_unit (code_unit),
		.last_unit (last_unit)
	);

endmodule
